// ----- design/snp_pkg.sv -----
// ----------------------------------------------------------------------------
// snp_pkg
// Shared types and constants for the serial packet deframer.
// ----------------------------------------------------------------------------
package snp_pkg;

    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_ENABLE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MATCH_ADDRESS = 8'd1;

    localparam logic [7:0] PRE_S = 8'h73;
    localparam logic [7:0] PRE_N = 8'h6E;
    localparam logic [7:0] PRE_P = 8'h70;

    localparam int unsigned HAS_DATA_BIT = 7;
    localparam int unsigned IS_BATCH_BIT = 6;
    localparam int unsigned LENGTH_LSB   = 2;
    localparam int unsigned LENGTH_BITS  = 4;

    typedef enum logic [3:0] {
        ST_HUNT_S,
        ST_HUNT_N,
        ST_HUNT_P,
        ST_TYPE,
        ST_ADDR,
        ST_DATA,
        ST_CK_HI,
        ST_CK_LO,
        ST_READ,
        ST_LOAD
    } snp_state_t;

    typedef struct packed {
        logic start_sum;
        logic add_sum;
        logic load_type;
        logic load_addr;
        logic data_byte;
        logic load_ck_hi;
        logic load_ck;
        logic rd_en;
        logic load_out;
        logic next_idx;
    } snp_cmd_t;

    typedef struct packed {
        logic is_s;
        logic is_n;
        logic is_p;
        logic addr_drop;
        logic has_words;
        logic data_done;
        logic final_item;
        logic out_free;
    } snp_status_t;

endpackage

// ----- design/snp_ctrl.sv -----
// ----------------------------------------------------------------------------
// snp_ctrl
// Frame state machine: preamble hunt, header, payload, checksum, item drain.
// ----------------------------------------------------------------------------
module snp_ctrl
    import snp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  snp_status_t sts,
    output snp_cmd_t    cmd
);

    snp_state_t state_reg;
    snp_state_t state_next;
    logic       accept;

    assign in_ready = (state_reg != ST_READ) && (state_reg != ST_LOAD);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT_S;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_HUNT_S:
            begin
                if (accept)
                begin
                    state_next = sts.is_s ? ST_HUNT_N : ST_HUNT_S;
                end
            end
            ST_HUNT_N:
            begin
                if (accept)
                begin
                    if (sts.is_n)
                        state_next = ST_HUNT_P;
                    else
                        state_next = sts.is_s ? ST_HUNT_N : ST_HUNT_S;
                end
            end
            ST_HUNT_P:
            begin
                if (accept)
                begin
                    if (sts.is_p)
                        state_next = ST_TYPE;
                    else
                        state_next = sts.is_s ? ST_HUNT_N : ST_HUNT_S;
                end
            end
            ST_TYPE:
            begin
                if (accept)
                    state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                if (accept)
                begin
                    if (sts.addr_drop)
                        state_next = ST_HUNT_S;
                    else if (sts.has_words)
                        state_next = ST_DATA;
                    else
                        state_next = ST_CK_HI;
                end
            end
            ST_DATA:
            begin
                if (accept && sts.data_done)
                    state_next = ST_CK_HI;
            end
            ST_CK_HI:
            begin
                if (accept)
                    state_next = ST_CK_LO;
            end
            ST_CK_LO:
            begin
                if (accept)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (sts.out_free)
                    state_next = sts.final_item ? ST_HUNT_S : ST_READ;
            end
            default:
            begin
                state_next = ST_HUNT_S;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_HUNT_S:
            begin
                cmd.start_sum = accept && sts.is_s;
            end
            ST_HUNT_N:
            begin
                cmd.add_sum   = accept && sts.is_n;
                cmd.start_sum = accept && !sts.is_n && sts.is_s;
            end
            ST_HUNT_P:
            begin
                cmd.add_sum   = accept && sts.is_p;
                cmd.start_sum = accept && !sts.is_p && sts.is_s;
            end
            ST_TYPE:
            begin
                cmd.add_sum   = accept;
                cmd.load_type = accept;
            end
            ST_ADDR:
            begin
                cmd.add_sum   = accept;
                cmd.load_addr = accept;
            end
            ST_DATA:
            begin
                cmd.add_sum   = accept;
                cmd.data_byte = accept;
            end
            ST_CK_HI:
            begin
                cmd.load_ck_hi = accept;
            end
            ST_CK_LO:
            begin
                cmd.load_ck = accept;
            end
            ST_READ:
            begin
                cmd.rd_en = 1'b1;
            end
            ST_LOAD:
            begin
                cmd.load_out = sts.out_free;
                cmd.next_idx = sts.out_free && !sts.final_item;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    ap_read_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |=> (state_reg == ST_LOAD))
        else $error("read not followed by load");

    ap_ck_then_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_ck |=> cmd.rd_en)
        else $error("checksum byte not followed by drain");

    ap_single_sum_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.start_sum && cmd.add_sum))
        else $error("conflicting checksum commands");

endmodule

// ----- design/snp_dp.sv -----
// ----------------------------------------------------------------------------
// snp_dp
// Deframer datapath: header and checksum registers, payload buffer, output
// register and configuration registers.
// ----------------------------------------------------------------------------
module snp_dp
    import snp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             rx_byte,
    input  snp_cmd_t               cmd,
    output snp_status_t            sts,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   status,
    output logic [7:0]             pkt_address,
    output logic [7:0]             pkt_type,
    output logic [3:0]             word_count,
    output logic [3:0]             word_index,
    output logic                   word_valid,
    output logic [31:0]            payload_word,
    output logic [15:0]            checksum_rx,
    output logic                   last
);

    localparam int unsigned DEPTH = 1 << LENGTH_BITS;
    localparam int unsigned CNT_W = LENGTH_BITS + 2;

    logic                   filter_enable_reg;
    logic [7:0]             match_address_reg;

    logic [7:0]             type_reg;
    logic [7:0]             addr_reg;
    logic [15:0]            sum_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [7:0]             ck_hi_reg;
    logic [15:0]            ck_reg;
    logic                   good_reg;
    logic [23:0]            asm_reg;
    logic [LENGTH_BITS-1:0] idx_reg;
    logic [31:0]            rd_data_reg;
    logic [31:0]            mem [DEPTH];

    logic                   out_valid_reg;
    logic                   status_reg;
    logic [7:0]             pkt_address_reg;
    logic [7:0]             pkt_type_reg;
    logic [3:0]             word_count_reg;
    logic [3:0]             word_index_reg;
    logic                   word_valid_reg;
    logic [31:0]            payload_word_reg;
    logic [15:0]            checksum_rx_reg;
    logic                   last_reg;

    logic [LENGTH_BITS-1:0] n_words;
    logic [CNT_W-1:0]       n_bytes;
    logic [CNT_W-1:0]       cnt_inc;
    logic [15:0]            sum_next;
    logic                   has_words;
    logic                   emit_words;
    logic                   wr_en;

    always_comb
    begin
        if (!type_reg[HAS_DATA_BIT])
            n_words = '0;
        else if (!type_reg[IS_BATCH_BIT])
            n_words = LENGTH_BITS'(1);
        else
            n_words = type_reg[LENGTH_LSB +: LENGTH_BITS];
    end

    assign has_words  = (n_words != '0);
    assign n_bytes    = {n_words, 2'b00};
    assign cnt_inc    = cnt_reg + CNT_W'(1);
    assign emit_words = good_reg && has_words;
    assign wr_en      = cmd.data_byte && (cnt_reg[1:0] == 2'b11);

    always_comb
    begin
        sum_next = sum_reg;
        if (cmd.start_sum)
            sum_next = {8'd0, rx_byte};
        else if (cmd.add_sum)
            sum_next = sum_reg + {8'd0, rx_byte};
    end

    assign sts.is_s       = (rx_byte == PRE_S);
    assign sts.is_n       = (rx_byte == PRE_N);
    assign sts.is_p       = (rx_byte == PRE_P);
    assign sts.addr_drop  = filter_enable_reg && (rx_byte != match_address_reg);
    assign sts.has_words  = has_words;
    assign sts.data_done  = (cnt_inc >= n_bytes);
    assign sts.final_item = !emit_words ||
                            ({1'b0, idx_reg} + (LENGTH_BITS + 1)'(1) == {1'b0, n_words});
    assign sts.out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_enable_reg <= 1'b0;
            match_address_reg <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_FILTER_ENABLE)
                filter_enable_reg <= cfg_data[0];
            else if (cfg_index == REG_MATCH_ADDRESS)
                match_address_reg <= cfg_data[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg  <= '0;
            addr_reg  <= '0;
            sum_reg   <= '0;
            cnt_reg   <= '0;
            ck_hi_reg <= '0;
            ck_reg    <= '0;
            good_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            if (cmd.load_type)
                type_reg <= rx_byte;
            if (cmd.load_addr)
            begin
                addr_reg <= rx_byte;
                cnt_reg  <= '0;
            end
            else if (cmd.data_byte)
            begin
                cnt_reg <= cnt_inc;
            end
            if (cmd.load_ck_hi)
                ck_hi_reg <= rx_byte;
            if (cmd.load_ck)
            begin
                ck_reg   <= {ck_hi_reg, rx_byte};
                good_reg <= ({ck_hi_reg, rx_byte} == sum_reg);
                idx_reg  <= '0;
            end
            else if (cmd.next_idx)
            begin
                idx_reg <= idx_reg + LENGTH_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.data_byte)
            asm_reg <= {asm_reg[15:0], rx_byte};
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[cnt_reg[CNT_W-1:2]] <= {asm_reg, rx_byte};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
            rd_data_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            status_reg       <= !good_reg;
            pkt_address_reg  <= addr_reg;
            pkt_type_reg     <= type_reg;
            word_count_reg   <= 4'(n_words);
            word_index_reg   <= 4'(idx_reg);
            word_valid_reg   <= emit_words;
            payload_word_reg <= emit_words ? rd_data_reg : 32'd0;
            checksum_rx_reg  <= ck_reg;
            last_reg         <= sts.final_item;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign pkt_address  = pkt_address_reg;
    assign pkt_type     = pkt_type_reg;
    assign word_count   = word_count_reg;
    assign word_index   = word_index_reg;
    assign word_valid   = word_valid_reg;
    assign payload_word = payload_word_reg;
    assign checksum_rx  = checksum_rx_reg;
    assign last         = last_reg;

    ap_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten");

    ap_data_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.data_byte |-> (cnt_reg < n_bytes))
        else $error("payload byte beyond packet length");

    ap_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && emit_words) |-> (idx_reg < n_words))
        else $error("word index beyond word count");

endmodule

// ----- design/snp_packet_deframer.sv -----
// ----------------------------------------------------------------------------
// snp_packet_deframer
// Throughput: one byte per cycle; after each packet that passes the address
//   filter the input stalls while items drain, each item a buffer read, then
//   an output load, which waits while the output register is held by the
//   receiver.
// Reset: asynchronous; hunt restarts, config clears, payload buffer is
//   not cleared.
// ----------------------------------------------------------------------------
module snp_packet_deframer
    import snp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             rx_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   status,
    output logic [7:0]             pkt_address,
    output logic [7:0]             pkt_type,
    output logic [3:0]             word_count,
    output logic [3:0]             word_index,
    output logic                   word_valid,
    output logic [31:0]            payload_word,
    output logic [15:0]            checksum_rx,
    output logic                   last,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    snp_cmd_t    cmd;
    snp_status_t sts;

    assign cfg_ready = 1'b1;

    snp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    snp_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_byte      (rx_byte),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .pkt_address  (pkt_address),
        .pkt_type     (pkt_type),
        .word_count   (word_count),
        .word_index   (word_index),
        .word_valid   (word_valid),
        .payload_word (payload_word),
        .checksum_rx  (checksum_rx),
        .last         (last)
    );

endmodule
